// ===== hdl/mrsc_pkg.sv =====
`timescale 1ns / 1ps

package mrsc_pkg;

	localparam logic [15:0] TICKS_RESET = 16'd1000;
	localparam logic [6:0]  PCT_MAX     = 7'd100;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_STOPPED = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		CMD_TICK         = 4'd0,
		CMD_START        = 4'd1,
		CMD_STOP         = 4'd2,
		CMD_TIMED_STOP   = 4'd3,
		CMD_RELEASE      = 4'd4,
		CMD_EXIT_STOP    = 4'd5,
		CMD_SET          = 4'd6,
		CMD_UP           = 4'd7,
		CMD_DOWN         = 4'd8,
		CMD_DISPLAY_DONE = 4'd9
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] percentage;
		logic [31:0] timeout_ms;
		logic        stop_button_pressed;
	} item_t;

	typedef struct packed {
		mode_t       mode;
		logic [6:0]  target_percentage;
		logic        display_update_needed;
		logic        stop_notice;
		logic [31:0] runtime_seconds;
		logic [31:0] start_count;
	} res_t;

endpackage

// ===== hdl/mrsc_core.sv =====
`timescale 1ns / 1ps

module mrsc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  logic           advance,
	input  mrsc_pkg::item_t item,
	output mrsc_pkg::res_t  result
);

	logic [15:0]     ticks_q;
	mrsc_pkg::mode_t mode_q, mode_d;
	logic [6:0]      target_q, target_d;
	logic            disp_q, disp_d;
	logic            armed_q, armed_d;
	logic [31:0]     len_q, len_d;
	logic [31:0]     elapsed_q, elapsed_d;
	logic [15:0]     run_cnt_q, run_cnt_d;
	logic [31:0]     runtime_q, runtime_d;
	logic [31:0]     starts_q, starts_d;
	logic            notice;
	logic [31:0]     elapsed_inc;
	logic [15:0]     run_cnt_inc;

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign run_cnt_inc = run_cnt_q + 16'd1;

	always_comb begin
		mode_d    = mode_q;
		target_d  = target_q;
		disp_d    = disp_q;
		armed_d   = armed_q;
		len_d     = len_q;
		elapsed_d = elapsed_q;
		run_cnt_d = run_cnt_q;
		runtime_d = runtime_q;
		starts_d  = starts_q;
		notice    = 1'b0;
		case (item.command)
			mrsc_pkg::CMD_TICK: begin
				if (mode_q == mrsc_pkg::MODE_STOPPED && armed_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= len_q) begin
						mode_d  = mrsc_pkg::MODE_IDLE;
						armed_d = 1'b0;
					end
				end
				if (mode_q == mrsc_pkg::MODE_RUNNING) begin
					if (run_cnt_inc >= ticks_q) begin
						runtime_d = runtime_q + 32'd1;
						run_cnt_d = '0;
					end else begin
						run_cnt_d = run_cnt_inc;
					end
				end
			end
			mrsc_pkg::CMD_START: begin
				if (mode_q == mrsc_pkg::MODE_IDLE) begin
					mode_d    = mrsc_pkg::MODE_RUNNING;
					starts_d  = starts_q + 32'd1;
					run_cnt_d = '0;
				end
			end
			mrsc_pkg::CMD_STOP: begin
				if (mode_q == mrsc_pkg::MODE_RUNNING) begin
					mode_d    = mrsc_pkg::MODE_STOPPED;
					elapsed_d = '0;
					armed_d   = 1'b0;
					notice    = 1'b1;
				end
			end
			mrsc_pkg::CMD_TIMED_STOP: begin
				if (mode_q == mrsc_pkg::MODE_RUNNING) begin
					mode_d    = mrsc_pkg::MODE_STOPPED;
					elapsed_d = '0;
					armed_d   = 1'b1;
					len_d     = item.timeout_ms;
					notice    = 1'b1;
				end
			end
			mrsc_pkg::CMD_RELEASE: begin
				if (mode_q == mrsc_pkg::MODE_STOPPED && !item.stop_button_pressed) begin
					mode_d  = mrsc_pkg::MODE_IDLE;
					armed_d = 1'b0;
				end
			end
			mrsc_pkg::CMD_EXIT_STOP: begin
				if (mode_q == mrsc_pkg::MODE_STOPPED) begin
					mode_d  = mrsc_pkg::MODE_IDLE;
					armed_d = 1'b0;
				end
			end
			mrsc_pkg::CMD_SET: begin
				if (item.percentage[15]) begin
					target_d = '0;
				end else if (item.percentage[14:0] > {8'd0, mrsc_pkg::PCT_MAX}) begin
					target_d = mrsc_pkg::PCT_MAX;
				end else begin
					target_d = item.percentage[6:0];
				end
				disp_d = 1'b1;
			end
			mrsc_pkg::CMD_UP: begin
				if (target_q < mrsc_pkg::PCT_MAX) begin
					target_d = target_q + 7'd1;
					disp_d   = 1'b1;
				end
			end
			mrsc_pkg::CMD_DOWN: begin
				if (target_q != '0) begin
					target_d = target_q - 7'd1;
					disp_d   = 1'b1;
				end
			end
			mrsc_pkg::CMD_DISPLAY_DONE: begin
				disp_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= mrsc_pkg::TICKS_RESET;
			mode_q    <= mrsc_pkg::MODE_IDLE;
			target_q  <= '0;
			disp_q    <= 1'b0;
			armed_q   <= 1'b0;
			len_q     <= '0;
			elapsed_q <= '0;
			run_cnt_q <= '0;
			runtime_q <= '0;
			starts_q  <= '0;
		end else begin
			if (cfg_we) begin
				ticks_q <= cfg_wdata;
			end
			if (advance) begin
				mode_q    <= mode_d;
				target_q  <= target_d;
				disp_q    <= disp_d;
				armed_q   <= armed_d;
				len_q     <= len_d;
				elapsed_q <= elapsed_d;
				run_cnt_q <= run_cnt_d;
				runtime_q <= runtime_d;
				starts_q  <= starts_d;
			end
		end
	end

	assign result.mode                  = mode_d;
	assign result.target_percentage     = target_d;
	assign result.display_update_needed = disp_d;
	assign result.stop_notice           = notice;
	assign result.runtime_seconds       = runtime_d;
	assign result.start_count           = starts_d;

endmodule

// ===== hdl/mrsc_skid.sv =====
`timescale 1ns / 1ps

module mrsc_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  mrsc_pkg::res_t in_data,
	output logic           in_ready,
	output logic           out_valid,
	output mrsc_pkg::res_t out_data,
	input  logic           out_ready
);

	logic           out_valid_q;
	mrsc_pkg::res_t out_q;
	logic           skid_valid_q;
	mrsc_pkg::res_t skid_q;
	logic           pop;

	assign pop      = out_valid_q && out_ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (in_valid) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (!out_valid_q || pop) begin
				out_q <= in_data;
			end else begin
				skid_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/motor_run_stop_controller_top.sv =====
`timescale 1ns / 1ps
// A word accepted on the input is held in the input register; its result word,
// computed by the core, is captured in the result register of the skid buffer.
// Throughput: one word per cycle while the two-entry result buffer has room.
// Reset: arst_n asynchronously clears the valid flags and the core state, but not
// the data registers; the tick period resets to 1000.

module motor_run_stop_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// percentage, timeout_ms, stop_button_pressed, zero fill
	input  logic [55:0] s_axis_tdata,
	// command
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mode, target_percentage, display_update_needed, stop_notice,
	// runtime_seconds, start_count, zero fill
	output logic [79:0] m_axis_tdata
);

	logic            s1_valid_q;
	mrsc_pkg::item_t item_s1;
	logic            skid_ready;
	logic            advance;
	logic            in_accept;
	mrsc_pkg::res_t  result;
	mrsc_pkg::res_t  out_data;

	assign advance       = s1_valid_q && skid_ready;
	assign s_axis_tready = !s1_valid_q || skid_ready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.command             <= mrsc_pkg::cmd_t'(s_axis_tuser);
			item_s1.percentage          <= s_axis_tdata[15:0];
			item_s1.timeout_ms          <= s_axis_tdata[47:16];
			item_s1.stop_button_pressed <= s_axis_tdata[48];
		end
	end

	mrsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item      (item_s1),
		.result    (result)
	);

	mrsc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (advance),
		.in_data   (result),
		.in_ready  (skid_ready),
		.out_valid (m_axis_tvalid),
		.out_data  (out_data),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {
		5'd0,
		out_data.start_count,
		out_data.runtime_seconds,
		out_data.stop_notice,
		out_data.display_update_needed,
		out_data.target_percentage,
		out_data.mode
	};

endmodule

// ===== hdl/mrsc_checker.sv =====
`timescale 1ns / 1ps

module mrsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata
);

	// A stop notice is only raised on the word that entered the stopped mode.
	a_notice_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[1:0] == mrsc_pkg::MODE_STOPPED)
		else $error("stop notice outside stopped mode");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("illegal mode code");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[8:2] <= mrsc_pkg::PCT_MAX)
		else $error("target percentage above limit");

	// Once a result word is taken, the buffer has room for the word held in the input stage.
	a_accept_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> s_axis_tready)
		else $error("input stalled after a result word was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

endmodule

bind motor_run_stop_controller_top mrsc_checker u_mrsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mrsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	motor_run_stop_controller_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	item_t command_q[$];
	res_t  status_q[$];
	item_t offered;
	int    src_wait;
	int    snk_wait;
	bit    src_steady;
	bit    snk_steady;
	int    mismatches;
	int    cycles;

	mode_t       ctl_mode = MODE_IDLE;
	logic [6:0]  ctl_target = '0;
	logic        ctl_display = 1'b0;
	logic        ctl_armed = 1'b0;
	logic [31:0] ctl_timeout = '0;
	logic [31:0] ctl_elapsed = '0;
	logic [15:0] ctl_run_ticks = '0;
	logic [31:0] ctl_runtime = '0;
	logic [31:0] ctl_starts = '0;
	logic [15:0] ctl_period = TICKS_RESET;

	function automatic res_t next_status(item_t w);
		res_t s;
		logic notice;
		notice = 1'b0;
		case (w.command)
			CMD_TICK: begin
				if (ctl_mode == MODE_STOPPED && ctl_armed) begin
					if (ctl_elapsed != 32'hFFFF_FFFF)
						ctl_elapsed = ctl_elapsed + 32'd1;
					if (ctl_elapsed >= ctl_timeout) begin
						ctl_mode = MODE_IDLE;
						ctl_armed = 1'b0;
					end
				end
				if (ctl_mode == MODE_RUNNING) begin
					ctl_run_ticks = ctl_run_ticks + 16'd1;
					if (ctl_run_ticks >= ctl_period) begin
						ctl_runtime = ctl_runtime + 32'd1;
						ctl_run_ticks = '0;
					end
				end
			end
			CMD_START: begin
				if (ctl_mode == MODE_IDLE) begin
					ctl_mode = MODE_RUNNING;
					ctl_starts = ctl_starts + 32'd1;
					ctl_run_ticks = '0;
				end
			end
			CMD_STOP, CMD_TIMED_STOP: begin
				if (ctl_mode == MODE_RUNNING) begin
					ctl_mode = MODE_STOPPED;
					ctl_elapsed = '0;
					notice = 1'b1;
					ctl_armed = (w.command == CMD_TIMED_STOP);
					if (w.command == CMD_TIMED_STOP)
						ctl_timeout = w.timeout_ms;
				end
			end
			CMD_RELEASE, CMD_EXIT_STOP: begin
				if (ctl_mode == MODE_STOPPED &&
				    (w.command == CMD_EXIT_STOP || !w.stop_button_pressed)) begin
					ctl_mode = MODE_IDLE;
					ctl_armed = 1'b0;
				end
			end
			CMD_SET: begin
				if ($signed(w.percentage) < 0)
					ctl_target = '0;
				else if ($signed(w.percentage) > $signed({9'd0, PCT_MAX}))
					ctl_target = PCT_MAX;
				else
					ctl_target = w.percentage[6:0];
				ctl_display = 1'b1;
			end
			CMD_UP: begin
				if (ctl_target < PCT_MAX) begin
					ctl_target = ctl_target + 7'd1;
					ctl_display = 1'b1;
				end
			end
			CMD_DOWN: begin
				if (ctl_target > 0) begin
					ctl_target = ctl_target - 7'd1;
					ctl_display = 1'b1;
				end
			end
			CMD_DISPLAY_DONE: begin
				ctl_display = 1'b0;
			end
			default: begin
			end
		endcase
		s.mode = ctl_mode;
		s.target_percentage = ctl_target;
		s.display_update_needed = ctl_display;
		s.stop_notice = notice;
		s.runtime_seconds = ctl_runtime;
		s.start_count = ctl_starts;
		return s;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
	                                    longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			src_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				status_q.push_back(next_status(offered));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_wait != 0) begin
					src_wait <= src_wait - 1;
					s_axis_tvalid <= 1'b0;
				end else if (command_q.size() != 0) begin
					offered = command_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'd0, offered.stop_button_pressed, offered.timeout_ms,
					                 offered.percentage};
					s_axis_tuser <= offered.command;
					if ($urandom_range(0, 39) == 0)
						src_steady = !src_steady;
					src_wait <= src_steady ? 0 : $urandom_range(0, 7);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int   g;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_wait <= 0;
		end else begin
			g = snk_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				if (status_q.size() == 0) begin
					mismatches++;
					$display("%0t: word expected none, got %h", $time, m_axis_tdata);
				end else begin
					want = status_q.pop_front();
					check_field("mode", want.mode, m_axis_tdata[1:0]);
					check_field("target_percentage", want.target_percentage,
					            m_axis_tdata[8:2]);
					check_field("display_update_needed", want.display_update_needed,
					            m_axis_tdata[9]);
					check_field("stop_notice", want.stop_notice, m_axis_tdata[10]);
					check_field("runtime_seconds", want.runtime_seconds,
					            m_axis_tdata[42:11]);
					check_field("start_count", want.start_count, m_axis_tdata[74:43]);
				end
				if ($urandom_range(0, 39) == 0)
					snk_steady = !snk_steady;
				g = snk_steady ? 0 : $urandom_range(0, 7);
			end
			if (g != 0) begin
				m_axis_tready <= 1'b0;
				snk_wait <= g - 1;
			end else begin
				m_axis_tready <= 1'b1;
				snk_wait <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic add_word(cmd_t c, logic [15:0] pct, logic [31:0] tmo, logic btn);
		item_t w;
		w.command = c;
		w.percentage = pct;
		w.timeout_ms = tmo;
		w.stop_button_pressed = btn;
		command_q.push_back(w);
	endtask

	task automatic add_random(int n);
		item_t w;
		int    r;
		repeat (n) begin
			w.percentage = 16'($urandom);
			w.timeout_ms = $urandom;
			w.stop_button_pressed = 1'($urandom);
			r = $urandom_range(0, 99);
			if (r < 40) begin
				w.command = CMD_TICK;
			end else if (r < 50) begin
				w.command = CMD_START;
			end else if (r < 56) begin
				w.command = CMD_STOP;
			end else if (r < 64) begin
				w.command = CMD_TIMED_STOP;
				if ($urandom_range(0, 9) != 0)
					w.timeout_ms = $urandom_range(0, 24);
			end else if (r < 70) begin
				w.command = CMD_RELEASE;
			end else if (r < 74) begin
				w.command = CMD_EXIT_STOP;
			end else if (r < 82) begin
				w.command = CMD_SET;
				if ($urandom_range(0, 3) != 0)
					w.percentage = 16'($urandom_range(0, 130)) - 16'd15;
			end else if (r < 88) begin
				w.command = CMD_UP;
			end else if (r < 94) begin
				w.command = CMD_DOWN;
			end else if (r < 98) begin
				w.command = CMD_DISPLAY_DONE;
			end else begin
				w.command = cmd_t'($urandom_range(10, 15));
			end
			command_q.push_back(w);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (command_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_period(logic [15:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ctl_period = v;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_word(CMD_SET, 16'h8000, $urandom, $urandom);
		add_word(CMD_SET, 16'h7FFF, $urandom, $urandom);
		add_word(CMD_UP, $urandom, $urandom, $urandom);
		add_word(CMD_DOWN, $urandom, $urandom, $urandom);
		add_word(CMD_SET, 16'h0000, $urandom, $urandom);
		add_word(CMD_DOWN, $urandom, $urandom, $urandom);
		add_word(CMD_UP, $urandom, $urandom, $urandom);
		add_word(CMD_DISPLAY_DONE, $urandom, $urandom, $urandom);
		add_word(CMD_START, $urandom, $urandom, $urandom);
		add_word(CMD_TICK, $urandom, $urandom, $urandom);
		add_word(CMD_STOP, $urandom, 32'hFFFF_FFFF, $urandom);
		add_word(CMD_START, $urandom, $urandom, $urandom);
		add_word(CMD_RELEASE, $urandom, $urandom, 1'b1);
		add_word(CMD_RELEASE, $urandom, $urandom, 1'b0);
		add_word(CMD_START, $urandom, $urandom, $urandom);
		add_word(CMD_TIMED_STOP, $urandom, 32'd0, $urandom);
		add_word(CMD_TICK, $urandom, $urandom, $urandom);
		add_word(CMD_START, $urandom, $urandom, $urandom);
		add_word(CMD_TIMED_STOP, $urandom, 32'd2, $urandom);
		add_word(CMD_TICK, $urandom, $urandom, $urandom);
		add_word(CMD_TICK, $urandom, $urandom, $urandom);
		add_word(CMD_START, $urandom, $urandom, $urandom);
		add_word(CMD_TIMED_STOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		add_word(CMD_TICK, $urandom, $urandom, $urandom);
		add_word(CMD_EXIT_STOP, $urandom, $urandom, $urandom);
		add_word(cmd_t'(4'd12), $urandom, $urandom, $urandom);
		add_word(cmd_t'(4'd15), $urandom, $urandom, $urandom);
		add_random(150);

		write_period(16'd3);
		add_random(300);
		write_period(16'd1);
		add_random(250);
		write_period(16'd0);
		add_random(200);
		write_period(16'hFFFF);
		add_random(200);
		write_period(16'd2);
		add_random(250);

		// Build up a long tick count, then lower the period while running.
		write_period(16'd50);
		add_word(CMD_EXIT_STOP, $urandom, $urandom, $urandom);
		add_word(CMD_START, $urandom, $urandom, $urandom);
		repeat (30) add_word(CMD_TICK, $urandom, $urandom, $urandom);
		write_period(16'd4);
		add_word(CMD_TICK, $urandom, $urandom, $urandom);
		add_random(250);
		write_period(TICKS_RESET);
		add_random(200);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
